FILE: rtl/alu_barrel_shifter_with_flags_assert.svh
// Assertion macros used by the checker file of the shifter ALU block.
`ifndef ALU_BARREL_SHIFTER_WITH_FLAGS_ASSERT_SVH
`define ALU_BARREL_SHIFTER_WITH_FLAGS_ASSERT_SVH

// Same-cycle implication, disabled while the reset expression is high.
`define ABSF_ASSERT_NOW(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("absf assertion failed");

// Next-cycle implication, disabled while the reset expression is high.
`define ABSF_ASSERT_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("absf assertion failed");

`endif

FILE: rtl/absf_pkg.sv
// Package: opcodes, shift types and the decoded word passed from front to back.
`default_nettype none
package absf_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int FLAG_N = 3;
    localparam int FLAG_Z = 2;
    localparam int FLAG_C = 1;
    localparam int FLAG_V = 0;

    typedef enum logic [3:0] {
        OP_AND = 4'h0,
        OP_EOR = 4'h1,
        OP_SUB = 4'h2,
        OP_RSB = 4'h3,
        OP_ADD = 4'h4,
        OP_ADC = 4'h5,
        OP_SBC = 4'h6,
        OP_RSC = 4'h7,
        OP_TST = 4'h8,
        OP_TEQ = 4'h9,
        OP_CMP = 4'hA,
        OP_CMN = 4'hB,
        OP_ORR = 4'hC,
        OP_MOV = 4'hD,
        OP_BIC = 4'hE,
        OP_MVN = 4'hF
    } t_opcode;

    typedef enum logic [1:0] {
        SH_LSL = 2'd0,
        SH_LSR = 2'd1,
        SH_ASR = 2'd2,
        SH_ROR = 2'd3
    } t_shift;

    typedef enum logic [1:0] {
        CIN_ZERO = 2'd0,
        CIN_ONE  = 2'd1,
        CIN_FLAG = 2'd2
    } t_cin;

    // Decoded word: operand 2 already shifted, only the old-carry parts left open.
    typedef struct packed {
        logic [31:0] first;
        logic [31:0] op2;
        logic        sh_carry;
        logic        keep_carry;
        logic        rrx;
        t_opcode     opcode;
        logic        is_arith;
        logic        swap;
        logic        invert;
        t_cin        cin_sel;
        logic        flag_upd;
        logic        write;
        logic [3:0]  rd;
    } t_work;

endpackage
`default_nettype wire

FILE: rtl/absf_front.sv
// Front end: decodes the instruction, runs the barrel shifter, classifies the ALU op.
`default_nettype none
module absf_front
    import absf_pkg::*;
(
    input  wire logic [31:0] i_instruction_word,
    input  wire logic [31:0] i_first_value,
    input  wire logic [31:0] i_second_value,
    input  wire logic [7:0]  i_shift_reg_value,
    output t_work            o_work
);

    logic [31:0] inst;
    logic [31:0] rm;
    logic [4:0]  rot;
    logic [31:0] imm_res;
    logic [63:0] imm_dbl;
    t_shift      sh_type;
    logic        reg_form;
    logic [4:0]  amt5;
    logic [7:0]  amt;
    logic        rrx;
    logic [5:0]  amt_sat;
    logic [5:0]  amt_asr;
    logic [32:0] lsl_t;
    logic [32:0] lsr_t;
    logic [32:0] asr_t;
    logic [63:0] ror_t;
    t_opcode     opc;

    assign inst     = i_instruction_word;
    assign rm       = i_second_value;
    assign rot      = {inst[11:8], 1'b0};
    assign imm_dbl  = {24'd0, inst[7:0], 24'd0, inst[7:0]} >> rot;
    assign imm_res  = imm_dbl[31:0];
    assign sh_type  = t_shift'(inst[6:5]);
    assign reg_form = inst[4];
    assign amt5     = inst[11:7];
    assign opc      = t_opcode'(inst[24:21]);

    // Immediate LSR/ASR by zero encode a shift by 32; ROR by zero is RRX.
    always_comb begin
        if (reg_form) begin
            amt = i_shift_reg_value;
        end else if (amt5 == 5'd0 && (sh_type == SH_LSR || sh_type == SH_ASR)) begin
            amt = 8'd32;
        end else begin
            amt = {3'd0, amt5};
        end
    end

    assign rrx     = !reg_form && amt5 == 5'd0 && sh_type == SH_ROR;
    assign amt_sat = (amt > 8'd33) ? 6'd33 : amt[5:0];
    assign amt_asr = (amt > 8'd32) ? 6'd32 : amt[5:0];
    assign lsl_t   = {1'b0, rm} << amt_sat;
    assign lsr_t   = {rm, 1'b0} >> amt_sat;
    assign asr_t   = $signed({rm, 1'b0}) >>> amt_asr;
    assign ror_t   = {rm, rm} >> amt[4:0];

    always_comb begin
        o_work            = '0;
        o_work.first      = i_first_value;
        o_work.opcode     = opc;
        o_work.rd         = inst[15:12];
        o_work.flag_upd   = inst[20] && inst[15:12] != 4'hF;
        o_work.write      = !(opc inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN});

        // Shifter
        if (inst[25]) begin
            o_work.op2        = imm_res;
            o_work.sh_carry   = imm_res[31];
            o_work.keep_carry = (rot == 5'd0);
        end else if (rrx) begin
            o_work.op2      = {1'b0, rm[31:1]};
            o_work.sh_carry = rm[0];
            o_work.rrx      = 1'b1;
        end else if (amt == 8'd0) begin
            o_work.op2        = rm;
            o_work.keep_carry = 1'b1;
        end else begin
            case (sh_type)
                SH_LSL: begin
                    o_work.op2      = lsl_t[31:0];
                    o_work.sh_carry = lsl_t[32];
                end
                SH_LSR: begin
                    o_work.op2      = lsr_t[32:1];
                    o_work.sh_carry = lsr_t[0];
                end
                SH_ASR: begin
                    o_work.op2      = asr_t[32:1];
                    o_work.sh_carry = asr_t[0];
                end
                default: begin
                    o_work.op2      = ror_t[31:0];
                    o_work.sh_carry = ror_t[31];
                end
            endcase
        end

        // ALU class
        case (opc)
            OP_SUB, OP_CMP: begin
                o_work.is_arith = 1'b1;
                o_work.invert   = 1'b1;
                o_work.cin_sel  = CIN_ONE;
            end
            OP_RSB: begin
                o_work.is_arith = 1'b1;
                o_work.swap     = 1'b1;
                o_work.invert   = 1'b1;
                o_work.cin_sel  = CIN_ONE;
            end
            OP_ADD, OP_CMN: begin
                o_work.is_arith = 1'b1;
                o_work.cin_sel  = CIN_ZERO;
            end
            OP_ADC: begin
                o_work.is_arith = 1'b1;
                o_work.cin_sel  = CIN_FLAG;
            end
            OP_SBC: begin
                o_work.is_arith = 1'b1;
                o_work.invert   = 1'b1;
                o_work.cin_sel  = CIN_FLAG;
            end
            OP_RSC: begin
                o_work.is_arith = 1'b1;
                o_work.swap     = 1'b1;
                o_work.invert   = 1'b1;
                o_work.cin_sel  = CIN_FLAG;
            end
            default: begin
                o_work.is_arith = 1'b0;
                o_work.cin_sel  = CIN_ZERO;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/absf_queue.sv
// Short queue of decoded words between the front and back ends.
`default_nettype none
module absf_queue
    import absf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  t_work      i_data,
    input  wire logic  i_pop,
    output t_work      o_data,
    output logic       o_full,
    output logic       o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_work            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/absf_back.sv
// Back end: ALU, NZCV flag register and the registered result word.
`default_nettype none
module absf_back
    import absf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_avail,
    input  t_work            i_work,
    output logic             o_pop,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_result_value,
    output logic             o_write_result,
    output logic [3:0]       o_dest_index,
    output logic             o_flag_negative,
    output logic             o_flag_zero,
    output logic             o_flag_carry,
    output logic             o_flag_overflow
);

    logic [3:0]  r_flags;
    logic [3:0]  n_flags;
    logic        r_out_valid;
    logic [31:0] r_result;
    logic        r_write;
    logic [3:0]  r_rd;
    logic [3:0]  r_out_flags;

    logic        c_old;
    logic [31:0] b;
    logic        sc;
    logic [31:0] x;
    logic [31:0] y;
    logic        cin;
    logic [32:0] sum;
    logic [31:0] res;

    assign o_pop = i_avail && (!r_out_valid || !i_out_stall);
    assign c_old = r_flags[FLAG_C];

    always_comb begin
        b     = i_work.op2;
        b[31] = i_work.rrx ? c_old : i_work.op2[31];
        sc    = i_work.keep_carry ? c_old : i_work.sh_carry;
        x     = i_work.swap ? b : i_work.first;
        y     = i_work.swap ? i_work.first : b;
        y     = i_work.invert ? ~y : y;
        case (i_work.cin_sel)
            CIN_ONE:  cin = 1'b1;
            CIN_FLAG: cin = c_old;
            default:  cin = 1'b0;
        endcase
        sum = {1'b0, x} + {1'b0, y} + {32'd0, cin};

        if (i_work.is_arith) begin
            res = sum[31:0];
        end else begin
            case (i_work.opcode)
                OP_AND, OP_TST: res = i_work.first & b;
                OP_EOR, OP_TEQ: res = i_work.first ^ b;
                OP_ORR:         res = i_work.first | b;
                OP_MOV:         res = b;
                OP_BIC:         res = i_work.first & ~b;
                default:        res = ~b;
            endcase
        end

        n_flags = r_flags;
        if (i_work.flag_upd) begin
            n_flags[FLAG_N] = res[31];
            n_flags[FLAG_Z] = (res == 32'd0);
            if (i_work.is_arith) begin
                n_flags[FLAG_C] = sum[32];
                n_flags[FLAG_V] = (x[31] ^ res[31]) & (y[31] ^ res[31]);
            end else begin
                n_flags[FLAG_C] = sc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_flags     <= n_flags;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result    <= res;
            r_write     <= i_work.write;
            r_rd        <= i_work.rd;
            r_out_flags <= n_flags;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_value  = r_result;
    assign o_write_result  = r_write;
    assign o_dest_index    = r_rd;
    assign o_flag_negative = r_out_flags[FLAG_N];
    assign o_flag_zero     = r_out_flags[FLAG_Z];
    assign o_flag_carry    = r_out_flags[FLAG_C];
    assign o_flag_overflow = r_out_flags[FLAG_V];

endmodule
`default_nettype wire

FILE: rtl/alu_barrel_shifter_with_flags.sv
// Top level: data-processing ALU with barrel shifter and NZCV flags.
// Path: an accepted word is written into the queue, then popped into the back end's result register.
// Throughput: one word per cycle while the output is not stalled; the flag loop (shifter carry,
// adder, NZCV register) closes within the back end.
// Reset: synchronous, active low; clears the queue, the output valid and the NZCV flags.
`default_nettype none
module alu_barrel_shifter_with_flags
    import absf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF  // decoded words buffered, 2 or more
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [31:0] i_instruction_word,
    input  wire logic [31:0] i_first_value,
    input  wire logic [31:0] i_second_value,
    input  wire logic [7:0]  i_shift_reg_value,
    // output channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_result_value,
    output logic             o_write_result,
    output logic [3:0]       o_dest_index,
    output logic             o_flag_negative,
    output logic             o_flag_zero,
    output logic             o_flag_carry,
    output logic             o_flag_overflow
);

    t_work front_work;
    t_work queue_work;
    logic  queue_full;
    logic  queue_empty;
    logic  push;
    logic  pop;

    // Front end: all of operand 2 that does not depend on the carry flag is
    // settled here, so the back end only patches RRX bit 31 and kept carries.
    absf_front u_front (
        .i_instruction_word (i_instruction_word),
        .i_first_value      (i_first_value),
        .i_second_value     (i_second_value),
        .i_shift_reg_value  (i_shift_reg_value),
        .o_work             (front_work)
    );

    // The stall comes from the registered fill count only, never from valid.
    assign o_in_stall = queue_full;
    assign push       = i_in_valid && !queue_full;

    absf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_work),
        .i_pop   (pop),
        .o_data  (queue_work),
        .o_full  (queue_full),
        .o_empty (queue_empty)
    );

    // Back end: pops whenever its output register is free or being emptied.
    absf_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_avail         (!queue_empty),
        .i_work          (queue_work),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_result_value  (o_result_value),
        .o_write_result  (o_write_result),
        .o_dest_index    (o_dest_index),
        .o_flag_negative (o_flag_negative),
        .o_flag_zero     (o_flag_zero),
        .o_flag_carry    (o_flag_carry),
        .o_flag_overflow (o_flag_overflow)
    );

endmodule
`default_nettype wire

FILE: rtl/absf_checker.sv
// Port-level checker for the shifter ALU block, bound to the top level.
`default_nettype none
`include "alu_barrel_shifter_with_flags_assert.svh"
module absf_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [31:0] o_result_value,
    input wire logic [3:0]  o_dest_index,
    input wire logic        o_flag_negative,
    input wire logic        o_flag_zero
);

    // Reset empties the output register.
    `ABSF_ASSERT_NEXT(a_reset_clears_out, i_clk, 1'b0, !i_rst_n, !o_out_valid)

    // A stalled result word holds.
    `ABSF_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_result_value) && $stable(o_dest_index))

    // A word taken while the output is empty gives a valid output once it has passed the queue and result register.
    `ABSF_ASSERT_NOW(a_in_reaches_out, i_clk, !i_rst_n,
        i_in_valid && !o_in_stall && !o_out_valid, ##2 o_out_valid)

    // N and Z are never set together: both come from one result, reset clears both.
    `ABSF_ASSERT_NOW(a_nz_exclusive, i_clk, !i_rst_n, o_out_valid,
        !(o_flag_negative && o_flag_zero))

endmodule

bind alu_barrel_shifter_with_flags absf_checker u_absf_checker (.*);
`default_nettype wire
